### rtl/c3rb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_pkg
// Shared widths, register indexes and payload types of the 3x3 convolution.
// ----------------------------------------------------------------------------
package c3rb_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned TAP_W  = 16;
	localparam int unsigned VAL_W  = 28;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned SZ_W   = 13;
	localparam int unsigned KROW_W = 48;
	localparam int unsigned CIDX_W = 3;
	localparam int unsigned PROD_W = TAP_W + PIX_W + 1;

	typedef logic [CIDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd1;
	localparam cfg_idx_t CFG_KROW_ZERO    = 3'd2;
	localparam cfg_idx_t CFG_KROW_ONE     = 3'd3;
	localparam cfg_idx_t CFG_KROW_TWO     = 3'd4;

	typedef logic [PIX_W-1:0]         pixel_t;
	typedef logic signed [VAL_W-1:0]  value_t;
	typedef logic [POS_W-1:0]         pos_t;

endpackage
`default_nettype wire

### rtl/c3rb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_in_if
// Pixel input channel: valid, ready and one grey level per beat.
// ----------------------------------------------------------------------------
interface c3rb_in_if;
	import c3rb_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

### rtl/c3rb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_out_if
// Result channel: valid, ready and one filtered pixel with its position per beat.
// ----------------------------------------------------------------------------
interface c3rb_out_if;
	import c3rb_pkg::*;
	logic   valid;
	logic   ready;
	value_t filtered_value;
	pos_t   out_row;
	pos_t   out_col;
	logic   last_of_run;
	modport source (output valid, output filtered_value, output out_row, output out_col,
		output last_of_run, input ready);
	modport sink (input valid, input filtered_value, input out_row, input out_col,
		input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/conv3x3_reflect_border_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_reflect_border_top
// Streaming 3x3 convolution of a raster image with mirrored borders.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the input is ready. The two previous rows
// sit in one RAM entry per column, read when a pixel is accepted and written
// back as it leaves the read stage, so one pixel per cycle holds away from the
// last column and row unless the output stalls. A pixel gives no result in the
// first row or column, one elsewhere, or two to four at the last column and in
// the last row; the emit stage sends these in turn and holds the input meanwhile.
// ----------------------------------------------------------------------------
module conv3x3_reflect_border_top
	import c3rb_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire c3rb_pkg::cfg_idx_t       cfg_idx,
	input  wire logic [c3rb_pkg::KROW_W-1:0] cfg_wdata,
	c3rb_in_if.sink                       pix_in,
	c3rb_out_if.source                    res_out
);
	import c3rb_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned HW = $clog2(MAX_HEIGHT);

	logic [SIZE_W-1:0] width_q, height_q;
	logic [KROW_W-1:0] krow_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1024);
			height_q <= SIZE_W'(1024);
			krow_q[0] <= '0;
			krow_q[1] <= '0;
			krow_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IMAGE_WIDTH:  width_q   <= cfg_wdata[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT: height_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_KROW_ZERO:    krow_q[0] <= cfg_wdata;
				CFG_KROW_ONE:     krow_q[1] <= cfg_wdata;
				CFG_KROW_TWO:     krow_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [SZ_W-1:0] w_eff, h_eff;
	always_comb begin
		if (width_q < SIZE_W'(3)) w_eff = SZ_W'(3);
		else if (SZ_W'(width_q) > SZ_W'(MAX_WIDTH)) w_eff = SZ_W'(MAX_WIDTH);
		else w_eff = SZ_W'(width_q);
		if (height_q < SIZE_W'(3)) h_eff = SZ_W'(3);
		else if (SZ_W'(height_q) > SZ_W'(MAX_HEIGHT)) h_eff = SZ_W'(MAX_HEIGHT);
		else h_eff = SZ_W'(height_q);
	end

	// Pipeline control.
	logic adv, accept, a_adv, b_free, last_s2;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;

	assign adv    = !out_valid_q || res_out.ready;
	assign b_free = !valid_s2 || (adv && last_s2);
	assign a_adv  = valid_s1 && b_free;
	assign pix_in.ready = !valid_s1 || a_adv;
	assign accept = pix_in.valid && pix_in.ready;

	// Raster position of the next pixel.
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic lc_now, lr_now;
	assign lc_now = SZ_W'(col_q) >= w_eff - SZ_W'(1);
	assign lr_now = SZ_W'(row_q) >= h_eff - SZ_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (lc_now) begin
				col_q <= '0;
				row_q <= lr_now ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Stage 1: line RAM read in flight.
	logic [AW-1:0] col_s1;
	logic [HW-1:0] row_s1;
	logic          lc_s1, lr_s1;
	pixel_t        px_s1;
	logic [2*PIX_W-1:0] line_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			lc_s1  <= lc_now;
			lr_s1  <= lr_now;
			px_s1  <= pix_in.pixel;
		end
	end

	// Upper byte holds the older row, lower byte the newer row.
	c3rb_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line_ram (
		.clk   (clk),
		.we    (a_adv),
		.waddr (col_s1),
		.wdata ({line_rd[PIX_W-1:0], px_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	// Stage 2: window and result sequencing.
	pixel_t win_q [3][3];
	logic   lc_s2, lr_s2, r_one_s2, c_one_s2;
	logic [1:0] kind_s2;
	logic [HW-1:0] row_s2;
	logic [AW-1:0] col_s2;
	logic has_next;

	assign has_next = (!kind_s2[0] && lc_s2) || (!kind_s2[1] && lr_s2);
	assign last_s2  = !has_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			kind_s2  <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (a_adv) begin
			valid_s2 <= (row_s1 != '0) && (col_s1 != '0);
			kind_s2  <= '0;
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= line_rd[2*PIX_W-1:PIX_W];
			win_q[1][2] <= line_rd[PIX_W-1:0];
			win_q[2][2] <= px_s1;
		end else if (adv && valid_s2) begin
			if (last_s2) begin
				valid_s2 <= 1'b0;
			end else if (!kind_s2[0] && lc_s2) begin
				kind_s2 <= {kind_s2[1], 1'b1};
			end else begin
				kind_s2 <= 2'b10;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_adv) begin
			lc_s2    <= lc_s1;
			lr_s2    <= lr_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			r_one_s2 <= row_s1 == HW'(1);
			c_one_s2 <= col_s1 == AW'(1);
		end
	end

	// Window slot for each tap, with the border folded onto the edge pixel.
	logic [1:0] wy [3];
	logic [1:0] wx [3];
	always_comb begin
		if (kind_s2[1]) begin
			wy[0] = 2'd2; wy[1] = 2'd2; wy[2] = 2'd1;
		end else begin
			wy[0] = 2'd2; wy[1] = 2'd1; wy[2] = r_one_s2 ? 2'd1 : 2'd0;
		end
		if (kind_s2[0]) begin
			wx[0] = 2'd2; wx[1] = 2'd2; wx[2] = 2'd1;
		end else begin
			wx[0] = 2'd2; wx[1] = 2'd1; wx[2] = c_one_s2 ? 2'd1 : 2'd0;
		end
	end

	logic [HW+POS_W:0] orow_ext;
	logic [AW+POS_W:0] ocol_ext;
	assign orow_ext = (HW+POS_W+1)'(row_s2) + (HW+POS_W+1)'(kind_s2[1]) - (HW+POS_W+1)'(1);
	assign ocol_ext = (AW+POS_W+1)'(col_s2) + (AW+POS_W+1)'(kind_s2[0]) - (AW+POS_W+1)'(1);

	// Stage 3: nine products.
	logic signed [PROD_W-1:0] prod_s3 [9];
	pos_t orow_s3, ocol_s3;
	logic last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					prod_s3[3*a+b] <= PROD_W'($signed(krow_q[a][TAP_W*b +: TAP_W])
						* $signed({1'b0, win_q[wy[a]][wx[b]]}));
				end
			end
			orow_s3 <= orow_ext[POS_W-1:0];
			ocol_s3 <= ocol_ext[POS_W-1:0];
			last_s3 <= last_s2;
		end
	end

	// Stage 4: sum into the output register.
	value_t sum;
	always_comb begin
		sum = '0;
		for (int k = 0; k < 9; k++) begin
			sum = sum + VAL_W'(prod_s3[k]);
		end
	end

	value_t val_q;
	pos_t   orow_q, ocol_q;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q  <= sum;
			orow_q <= orow_s3;
			ocol_q <= ocol_s3;
			last_q <= last_s3;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.filtered_value = val_q;
	assign res_out.out_row        = orow_q;
	assign res_out.out_col        = ocol_q;
	assign res_out.last_of_run    = last_q;

	// The write-back never targets the column being read in the same cycle.
	a_no_ram_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(a_adv && accept) |-> (col_s1 != col_q))
		else $error("line RAM read and write hit the same column");

	// A column or row step of a pixel is only taken once the matching edge flag allows it.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2[0]) |-> lc_s2)
		else $error("column step taken outside the last column");

	a_row_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2[1]) |-> lr_s2)
		else $error("row step taken outside the last row");

	// A stalled emit stage keeps the input closed.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !adv) |-> !pix_in.ready)
		else $error("input accepted while the emit stage is stalled");
endmodule
`default_nettype wire

### rtl/c3rb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c3rb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module c3rb_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### tb/sv/conv3x3_reflect_border_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_reflect_border_checker
// Watches the configuration port and both channels of the 3x3 convolution,
// predicts every result from the accepted pixels and compares each result
// beat field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module conv3x3_reflect_border_checker
	import c3rb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire cfg_idx_t          cfg_idx,
	input  wire logic [KROW_W-1:0] cfg_wdata,
	c3rb_in_if                     pix_mon,
	c3rb_out_if                    res_mon,
	output int                     errors,
	output int                     pending,
	output int                     results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		value_t value;
		pos_t   row;
		pos_t   col;
		logic   last;
	} filtered_t;

	filtered_t   expected_q[$];
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	logic [47:0] kernel_reg [3];
	pixel_t      row_above2 [DEF_MAX_WIDTH];
	pixel_t      row_above1 [DEF_MAX_WIDTH];
	pixel_t      win [3][3];
	int          cur_row;
	int          cur_col;

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
	end

	function automatic int clamp_size(int v);
		if (v < 3) return 3;
		if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return v;
	endfunction

	function automatic filtered_t conv_at(int r, int c, int orow, int ocol, logic last);
		logic signed [63:0] sum;
		logic signed [15:0] k;
		filtered_t f;
		int y, x, wy, wx;
		sum = '0;
		for (int a = 0; a < 3; a++) begin
			y = orow + 1 - a;
			if (y < 0) y = 0;
			if (y > r) y = r;
			for (int b = 0; b < 3; b++) begin
				x = ocol + 1 - b;
				if (x < 0) x = 0;
				if (x > c) x = c;
				wy = y - (r - 2);
				wx = x - (c - 2);
				if (wy < 0) wy = 0;
				if (wy > 2) wy = 2;
				if (wx < 0) wx = 0;
				if (wx > 2) wx = 2;
				k = kernel_reg[a][16*b +: 16];
				sum = sum + 64'(k) * $signed({56'd0, win[wy][wx]});
			end
		end
		f.value = sum[VAL_W-1:0];
		f.row = orow[POS_W-1:0];
		f.col = ocol[POS_W-1:0];
		f.last = last;
		return f;
	endfunction

	task automatic predict_pixel(pixel_t px);
		int w, h, ci, total, n;
		logic at_last_col, at_last_row;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		ci = cur_col < DEF_MAX_WIDTH ? cur_col : DEF_MAX_WIDTH - 1;
		at_last_col = cur_col >= w - 1;
		at_last_row = cur_row >= h - 1;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = row_above2[ci];
		win[1][2] = row_above1[ci];
		win[2][2] = px;
		row_above2[ci] = row_above1[ci];
		row_above1[ci] = px;
		if (cur_row >= 1 && cur_col >= 1) begin
			total = at_last_col ? 2 : 1;
			if (at_last_row) total = total * 2;
			n = 1;
			expected_q.insert(expected_q.size(), conv_at(cur_row, cur_col,
				cur_row - 1, cur_col - 1, n == total));
			if (at_last_col) begin
				n++;
				expected_q.insert(expected_q.size(), conv_at(cur_row, cur_col,
					cur_row - 1, cur_col, n == total));
			end
			if (at_last_row) begin
				n++;
				expected_q.insert(expected_q.size(), conv_at(cur_row, cur_col,
					cur_row, cur_col - 1, n == total));
				if (at_last_col) begin
					n++;
					expected_q.insert(expected_q.size(), conv_at(cur_row, cur_col,
						cur_row, cur_col, n == total));
				end
			end
		end
		if (at_last_col) begin
			cur_col = 0;
			cur_row = at_last_row ? 0 : cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
	endtask

	task automatic report(string field, longint got, longint want, filtered_t e);
		$display("MISMATCH %s: got %0d, expected %0d (row %0d col %0d)",
			field, got, want, e.row, e.col);
		errors++;
	endtask

	always @(negedge clk) begin
		filtered_t e;
		if (!arst_n) begin
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			for (int i = 0; i < 3; i++) kernel_reg[i] = '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			cur_row = 0;
			cur_col = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IMAGE_WIDTH: width_reg = cfg_wdata[10:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[10:0];
					CFG_KROW_ZERO: kernel_reg[0] = cfg_wdata;
					CFG_KROW_ONE: kernel_reg[1] = cfg_wdata;
					CFG_KROW_TWO: kernel_reg[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (pix_mon.valid && pix_mon.ready) predict_pixel(pix_mon.pixel);
			if (res_mon.valid && res_mon.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$display("MISMATCH unexpected result beat at row %0d col %0d",
						res_mon.out_row, res_mon.out_col);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (res_mon.filtered_value !== e.value)
						report("filtered_value", res_mon.filtered_value, e.value, e);
					if (res_mon.out_row !== e.row)
						report("out_row", res_mon.out_row, e.row, e);
					if (res_mon.out_col !== e.col)
						report("out_col", res_mon.out_col, e.col, e);
					if (res_mon.last_of_run !== e.last)
						report("last_of_run", res_mon.last_of_run, e.last, e);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule
`default_nettype wire

### tb/sv/tb_conv3x3_reflect_border_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_conv3x3_reflect_border_top
// Drives whole frames through the 3x3 convolution under a range of sizes and
// kernels, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_conv3x3_reflect_border_top;
	import c3rb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_idx;
	logic [KROW_W-1:0] cfg_wdata;
	int                errors;
	int                pending;
	int                results_seen;
	int                cycles;
	int                frames_run;
	int                pixels_sent;
	int                frame_left;
	bit                no_idle;
	bit                stall_done;
	int                hold_left;

	c3rb_in_if  pix_in ();
	c3rb_out_if res_out ();

	conv3x3_reflect_border_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .pix_in(pix_in.sink), .res_out(res_out.source)
	);

	conv3x3_reflect_border_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .pix_mon(pix_in), .res_mon(res_out),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_IMAGE_WIDTH;
		cfg_wdata = '0;
		pix_in.valid = 1'b0;
		pix_in.pixel = '0;
		res_out.ready = 1'b0;
		cycles = 0;
		no_idle = 1'b0;
		stall_done = 1'b0;
		hold_left = 0;
		frame_left = 0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int idle_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiver holds off once for a long stretch so the block backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_out.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_out.ready <= 1'b0;
		end else if (!stall_done && results_seen >= 120 && frame_left >= 20) begin
			stall_done <= 1'b1;
			hold_left <= 300;
			res_out.ready <= 1'b0;
		end else begin
			res_out.ready <= (idle_gap() == 0);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [KROW_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
	endtask

	task automatic send_pixel(pixel_t px);
		int gap;
		bit took;
		gap = idle_gap();
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.pixel <= px;
		do begin
			@(negedge clk);
			took = pix_in.ready;
			@(posedge clk);
		end while (!took);
		pixels_sent++;
	endtask

	function automatic logic [15:0] pick_tap();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] pick_row();
		return {pick_tap(), pick_tap(), pick_tap()};
	endfunction

	function automatic pixel_t pick_pixel(int style);
		if (style == 1) return 8'hFF;
		if (style == 2) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_frame(int w_raw, int h_raw, logic [KROW_W-1:0] k0,
		logic [KROW_W-1:0] k1, logic [KROW_W-1:0] k2, int style);
		int w, h;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(CFG_IMAGE_WIDTH, KROW_W'(w_raw));
		write_reg(CFG_IMAGE_HEIGHT, KROW_W'(h_raw));
		write_reg(CFG_KROW_ZERO, k0);
		write_reg(CFG_KROW_ONE, k1);
		write_reg(CFG_KROW_TWO, k2);
		if ($urandom_range(0, 3) == 0)
			write_reg(cfg_idx_t'($urandom_range(5, 7)), KROW_W'({$urandom, $urandom}));
		@(posedge clk);
		cfg_we <= 1'b0;
		w = (w_raw % 2048) < 3 ? 3 : ((w_raw % 2048) > 1024 ? 1024 : w_raw % 2048);
		h = (h_raw % 2048) < 3 ? 3 : ((h_raw % 2048) > 1024 ? 1024 : h_raw % 2048);
		for (int i = 0; i < w * h; i++) begin
			frame_left = w * h - i;
			send_pixel(pick_pixel(style));
		end
		frame_left = 0;
		pix_in.valid <= 1'b0;
		frames_run++;
	endtask

	initial begin
		frames_run = 0;
		pixels_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_frame(3, 3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 1);
		run_frame(2, 0, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 2);
		run_frame(3, 2, 48'h0001_0002_0003, 48'h0004_0005_0006, 48'h0007_0008_0009, 0);
		while (pixels_sent < 280) begin
			no_idle = ($urandom_range(0, 4) == 0);
			run_frame($urandom_range(3, 9), $urandom_range(3, 7), pick_row(), pick_row(),
				pick_row(), 0);
		end
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d frames, %0d pixels in, %0d results checked.",
			frames_run, pixels_sent, results_seen);
		$display("Small frames from the 3x3 minimum up, with extreme taps and one long stall.");
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
rtl/c3rb_pkg.sv
rtl/c3rb_in_if.sv
rtl/c3rb_out_if.sv
rtl/c3rb_ram.sv
rtl/conv3x3_reflect_border_top.sv
tb/sv/conv3x3_reflect_border_checker.sv
tb/sv/tb_conv3x3_reflect_border_top.sv
